@@ rtl/pal_pkg.sv @@
package pal_pkg;

  // Palette RAM geometry. The RAM is held as little-endian words, one byte lane each side.
  localparam int unsigned WINDOW_BYTES     = 3072;
  localparam int unsigned COLORS_PER_GROUP = 256;
  localparam int unsigned GROUP_WORDS      = WINDOW_BYTES / 2;
  localparam int unsigned MEM_WORDS        = 2 * GROUP_WORDS;
  localparam int unsigned MEM_AW           = $clog2(MEM_WORDS);
  localparam int unsigned GREEN_WORD_OFS   = 'h400 / 2;
  localparam int unsigned BLUE_WORD_OFS    = 'h800 / 2;

  // Upper address bits of the two windows; both bases sit on a 4 KiB boundary.
  localparam logic [7:0] WIN0_PAGE = 8'hC8;
  localparam logic [7:0] WIN1_PAGE = 8'hCC;

  // Bus commands.
  localparam logic [2:0] CMD_MEM_RD    = 3'd0;
  localparam logic [2:0] CMD_MEM_WR    = 3'd1;
  localparam logic [2:0] CMD_PORT_WR_B = 3'd2;
  localparam logic [2:0] CMD_PORT_WR_W = 3'd3;
  localparam logic [2:0] CMD_PORT_RD_W = 3'd4;

  // I/O ports.
  localparam logic [7:0] PORT_BLANK     = 8'h02;
  localparam logic [7:0] PORT_LATCH     = 8'h04;
  localparam logic [7:0] PORT_RASTER    = 8'h06;
  localparam logic [7:0] PORT_ZERO_A    = 8'h40;
  localparam logic [7:0] PORT_ZERO_B    = 8'h42;
  localparam logic [7:0] PORT_SCROLL_Y0 = 8'h80;
  localparam logic [7:0] PORT_SCROLL_X0 = 8'h82;
  localparam logic [7:0] PORT_SCROLL_Y1 = 8'h84;
  localparam logic [7:0] PORT_SCROLL_X1 = 8'h86;

  localparam logic [15:0] DIP_RESET   = 16'hFDFB;
  localparam logic [15:0] RASTER_BIAS = 16'd128;
  localparam logic [15:0] OPEN_BUS    = 16'h00FF;
  localparam logic [15:0] ALL_ONES    = 16'hFFFF;
  localparam int unsigned BLANK_BIT   = 3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_OPEN,
    OP_MEM_RD,
    OP_PAL_WR,
    OP_SET_BLANK,
    OP_LATCH,
    OP_SET_RASTER,
    OP_SET_SCROLL,
    OP_RD_DIP,
    OP_RD_ZERO,
    OP_RD_ONES
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [MEM_AW-1:0] word_addr;
    logic              lane;
    logic              group;
    logic [7:0]        color;
    logic [1:0]        scroll_sel;
    logic [15:0]       data;
  } op_t;

endpackage

@@ rtl/pal_front.sv @@
module pal_front (
  input  logic [2:0]      command_i,
  input  logic [19:0]     mem_address_i,
  input  logic [7:0]      port_number_i,
  input  logic [15:0]     write_data_i,
  output pal_pkg::op_t    op_o
);

  logic        in_win0;
  logic        in_win1;
  logic        in_win;
  logic [11:0] offset;

  assign offset  = mem_address_i[11:0];
  assign in_win0 = (mem_address_i[19:12] == pal_pkg::WIN0_PAGE) &&
                   (offset < 12'(pal_pkg::WINDOW_BYTES));
  assign in_win1 = (mem_address_i[19:12] == pal_pkg::WIN1_PAGE) &&
                   (offset < 12'(pal_pkg::WINDOW_BYTES));
  assign in_win  = in_win0 || in_win1;

  always_comb begin
    op_o            = '0;
    op_o.kind       = pal_pkg::OP_NONE;
    op_o.word_addr  = pal_pkg::MEM_AW'(offset[11:1]) +
                      (in_win1 ? pal_pkg::MEM_AW'(pal_pkg::GROUP_WORDS) : '0);
    op_o.lane       = offset[0];
    op_o.group      = in_win1;
    op_o.color      = offset[8:1];
    op_o.scroll_sel = port_number_i[2:1];
    op_o.data       = write_data_i;

    unique case (command_i)
      pal_pkg::CMD_MEM_RD: begin
        op_o.kind = in_win ? pal_pkg::OP_MEM_RD : pal_pkg::OP_RD_OPEN;
      end
      pal_pkg::CMD_MEM_WR: begin
        op_o.kind = in_win ? pal_pkg::OP_PAL_WR : pal_pkg::OP_NONE;
      end
      pal_pkg::CMD_PORT_WR_B: begin
        if (port_number_i == pal_pkg::PORT_BLANK) begin
          op_o.kind = pal_pkg::OP_SET_BLANK;
        end else if (port_number_i == pal_pkg::PORT_LATCH) begin
          op_o.kind = pal_pkg::OP_LATCH;
        end
      end
      pal_pkg::CMD_PORT_WR_W: begin
        case (port_number_i) inside
          pal_pkg::PORT_BLANK:  op_o.kind = pal_pkg::OP_SET_BLANK;
          pal_pkg::PORT_LATCH:  op_o.kind = pal_pkg::OP_LATCH;
          pal_pkg::PORT_RASTER: op_o.kind = pal_pkg::OP_SET_RASTER;
          pal_pkg::PORT_SCROLL_Y0, pal_pkg::PORT_SCROLL_X0,
          pal_pkg::PORT_SCROLL_Y1, pal_pkg::PORT_SCROLL_X1: begin
            op_o.kind = pal_pkg::OP_SET_SCROLL;
          end
          default: op_o.kind = pal_pkg::OP_NONE;
        endcase
      end
      pal_pkg::CMD_PORT_RD_W: begin
        case (port_number_i) inside
          pal_pkg::PORT_LATCH:               op_o.kind = pal_pkg::OP_RD_DIP;
          pal_pkg::PORT_ZERO_A, pal_pkg::PORT_ZERO_B: op_o.kind = pal_pkg::OP_RD_ZERO;
          default:                           op_o.kind = pal_pkg::OP_RD_ONES;
        endcase
      end
      default: op_o.kind = pal_pkg::OP_NONE;
    endcase
  end

endmodule

@@ rtl/pal_queue.sv @@
module pal_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pal_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output pal_pkg::op_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pal_pkg::op_t slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/pal_back.sv @@
module pal_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         q_empty_i,
  input  pal_pkg::op_t q_head_i,
  output logic         q_pop_o,
  output logic         clearing_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [15:0]  read_data_o,
  output logic         palette_updated_o,
  output logic [8:0]   palette_index_o,
  output logic [15:0]  palette_color_o,
  output logic         sprite_latch_pulse_o,
  output logic         video_blank_o,
  output logic [15:0]  raster_line_o,
  output logic [15:0]  scroll_y_layer0_o,
  output logic [15:0]  scroll_x_layer0_o,
  output logic [15:0]  scroll_y_layer1_o,
  output logic [15:0]  scroll_x_layer1_o
);

  localparam int unsigned AW = pal_pkg::MEM_AW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RB_R,
    ST_RB_G,
    ST_RB_B,
    ST_EMIT
  } state_e;

  state_e       state_q;
  logic [AW-1:0] clr_q;
  pal_pkg::op_t op_q;
  logic [15:0]  dip_q;
  logic         blank_q;
  logic [15:0]  raster_q;
  logic [15:0]  scroll_q [4];
  logic [4:0]   red_q;
  logic [4:0]   green_q;

  logic         out_valid_q;
  logic [15:0]  read_data_q;
  logic         updated_q;
  logic [8:0]   index_q;
  logic [15:0]  color_q;
  logic         pulse_q;
  logic         blank_out_q;
  logic [15:0]  raster_out_q;
  logic [15:0]  scroll_out_q [4];

  // Palette RAM, split into even and odd byte lanes of one word address.
  logic [7:0]   mem_lo_q [pal_pkg::MEM_WORDS];
  logic [7:0]   mem_hi_q [pal_pkg::MEM_WORDS];
  logic [7:0]   rd_lo_q;
  logic [7:0]   rd_hi_q;

  logic          mem_we_lo;
  logic          mem_we_hi;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] red_addr;
  logic          emit_load;
  logic [15:0]   rd_word;
  logic [7:0]    rd_byte;

  assign red_addr = (op_q.group ? AW'(pal_pkg::GROUP_WORDS) : '0) + AW'(op_q.color);
  assign q_pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign clearing_o = (state_q == ST_CLEAR);
  assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign rd_byte    = op_q.lane ? rd_hi_q : rd_lo_q;

  always_comb begin
    mem_we_lo = 1'b0;
    mem_we_hi = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = q_head_i.word_addr;
    mem_wdata = q_head_i.data[7:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_lo = 1'b1;
        mem_we_hi = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.kind == pal_pkg::OP_PAL_WR) begin
            mem_we_lo = !q_head_i.lane;
            mem_we_hi = q_head_i.lane;
          end
          mem_re = (q_head_i.kind == pal_pkg::OP_MEM_RD);
        end
      end
      ST_RB_R: begin
        mem_re   = 1'b1;
        mem_addr = red_addr;
      end
      ST_RB_G: begin
        mem_re   = 1'b1;
        mem_addr = red_addr + AW'(pal_pkg::GREEN_WORD_OFS);
      end
      ST_RB_B: begin
        mem_re   = 1'b1;
        mem_addr = red_addr + AW'(pal_pkg::BLUE_WORD_OFS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_lo) begin
      mem_lo_q[mem_addr] <= mem_wdata;
    end
    if (mem_we_hi) begin
      mem_hi_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_lo_q <= mem_lo_q[mem_addr];
      rd_hi_q <= mem_hi_q[mem_addr];
    end
  end

  always_comb begin
    case (op_q.kind)
      pal_pkg::OP_MEM_RD:  rd_word = {8'd0, rd_byte};
      pal_pkg::OP_RD_OPEN: rd_word = pal_pkg::OPEN_BUS;
      pal_pkg::OP_RD_DIP:  rd_word = dip_q;
      pal_pkg::OP_RD_ONES: rd_word = pal_pkg::ALL_ONES;
      default:             rd_word = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      op_q         <= '0;
      dip_q        <= pal_pkg::DIP_RESET;
      blank_q      <= 1'b0;
      raster_q     <= '0;
      scroll_q     <= '{default: '0};
      red_q        <= '0;
      green_q      <= '0;
      out_valid_q  <= 1'b0;
      read_data_q  <= '0;
      updated_q    <= 1'b0;
      index_q      <= '0;
      color_q      <= '0;
      pulse_q      <= 1'b0;
      blank_out_q  <= 1'b0;
      raster_out_q <= '0;
      scroll_out_q <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        dip_q <= cfg_data_i;
      end
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(pal_pkg::MEM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty_i) begin
            op_q <= q_head_i;
            case (q_head_i.kind)
              pal_pkg::OP_SET_BLANK:  blank_q <= q_head_i.data[pal_pkg::BLANK_BIT];
              pal_pkg::OP_SET_RASTER: begin
                raster_q <= {7'd0, q_head_i.data[8:0]} - pal_pkg::RASTER_BIAS;
              end
              pal_pkg::OP_SET_SCROLL: scroll_q[q_head_i.scroll_sel] <= q_head_i.data;
              default: begin
              end
            endcase
            state_q <= (q_head_i.kind == pal_pkg::OP_PAL_WR) ? ST_RB_R : ST_EMIT;
          end
        end
        ST_RB_R: begin
          state_q <= ST_RB_G;
        end
        ST_RB_G: begin
          red_q   <= rd_lo_q[4:0];
          state_q <= ST_RB_B;
        end
        ST_RB_B: begin
          green_q <= rd_lo_q[4:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_q  <= 1'b1;
            read_data_q  <= rd_word;
            updated_q    <= (op_q.kind == pal_pkg::OP_PAL_WR);
            index_q      <= (op_q.kind == pal_pkg::OP_PAL_WR) ? {op_q.group, op_q.color} : '0;
            color_q      <= (op_q.kind == pal_pkg::OP_PAL_WR) ?
                            {red_q, green_q, green_q[4], rd_lo_q[4:0]} : '0;
            pulse_q      <= (op_q.kind == pal_pkg::OP_LATCH);
            blank_out_q  <= blank_q;
            raster_out_q <= raster_q;
            scroll_out_q <= scroll_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = read_data_q;
  assign palette_updated_o    = updated_q;
  assign palette_index_o      = index_q;
  assign palette_color_o      = color_q;
  assign sprite_latch_pulse_o = pulse_q;
  assign video_blank_o        = blank_out_q;
  assign raster_line_o        = raster_out_q;
  assign scroll_y_layer0_o    = scroll_out_q[0];
  assign scroll_x_layer0_o    = scroll_out_q[1];
  assign scroll_y_layer1_o    = scroll_out_q[2];
  assign scroll_x_layer1_o    = scroll_out_q[3];

endmodule

@@ rtl/palette_ram_and_video_ports.sv @@
// Palette RAM and video control ports for an emulated CPU bus.
// The input channel (in_valid_i / in_stall_o) carries one bus access per transfer:
// a byte memory read or write, a byte or word port write, or a word port read.
// The output channel (out_valid_o / out_stall_i) returns exactly one result per
// access, in order, holding the read data, any rebuilt palette entry and the video
// control registers as they stand after that access.
// The DIP word is written through cfg_we_i / cfg_data_i; the user must do so
// only while the block is idle, and the block itself does not enforce it.
// An access passes through the queue to the back end, which registers its result
// in the output register; for a palette write the back end first writes the byte
// and then reads the red, green and blue words over its single RAM port. The back
// end finishes one access before it takes the next.
// After reset the palette RAM is cleared one word a cycle, all 3072 words, during
// which in_stall_o stays high; configuration writes are taken as ever.
// When the receiver stalls, the finished result holds in the output register and
// the queue keeps taking accesses until it is full, then in_stall_o rises.
module palette_ram_and_video_ports #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [19:0] mem_address_i,
  input  logic [7:0]  port_number_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        palette_updated_o,
  output logic [8:0]  palette_index_o,
  output logic [15:0] palette_color_o,
  output logic        sprite_latch_pulse_o,
  output logic        video_blank_o,
  output logic [15:0] raster_line_o,
  output logic [15:0] scroll_y_layer0_o,
  output logic [15:0] scroll_x_layer0_o,
  output logic [15:0] scroll_y_layer1_o,
  output logic [15:0] scroll_x_layer1_o
);

  pal_pkg::op_t front_op;
  pal_pkg::op_t head_op;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  logic         clearing;
  logic         in_transfer;

  // Nothing is taken while the palette RAM is being cleared or the queue is full.
  assign in_stall_o  = q_full || clearing;
  assign in_transfer = in_valid_i && !in_stall_o;

  // The front end decodes the address window, port number and command.
  pal_front u_front (
    .command_i     (command_i),
    .mem_address_i (mem_address_i),
    .port_number_i (port_number_i),
    .write_data_i  (write_data_i),
    .op_o          (front_op)
  );

  // The queue lets new accesses arrive while the back end is busy or stalled.
  pal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_transfer),
    .push_op_i (front_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (head_op)
  );

  // The back end owns the palette RAM, the video registers and the result register.
  pal_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .q_empty_i            (q_empty),
    .q_head_i             (head_op),
    .q_pop_o              (q_pop),
    .clearing_o           (clearing),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .read_data_o          (read_data_o),
    .palette_updated_o    (palette_updated_o),
    .palette_index_o      (palette_index_o),
    .palette_color_o      (palette_color_o),
    .sprite_latch_pulse_o (sprite_latch_pulse_o),
    .video_blank_o        (video_blank_o),
    .raster_line_o        (raster_line_o),
    .scroll_y_layer0_o    (scroll_y_layer0_o),
    .scroll_x_layer0_o    (scroll_x_layer0_o),
    .scroll_y_layer1_o    (scroll_y_layer1_o),
    .scroll_x_layer1_o    (scroll_x_layer1_o)
  );

endmodule

@@ rtl/pal_checker.sv @@
module pal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] read_data_o,
  input logic        palette_updated_o,
  input logic [8:0]  palette_index_o,
  input logic [15:0] palette_color_o,
  input logic        sprite_latch_pulse_o,
  input logic [15:0] raster_line_o
);

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Entry fields are zero unless a palette entry was rebuilt.
  a_no_update_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !palette_updated_o |-> (palette_index_o == '0) && (palette_color_o == '0))
    else $error("palette fields set without an update");

  // A palette write returns no read data and no latch pulse.
  a_update_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && palette_updated_o |-> (read_data_o == '0) && !sprite_latch_pulse_o)
    else $error("palette update mixed with other results");

  // The raster line is a nine-bit value less the bias, so it lies in a narrow band.
  a_raster_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (raster_line_o < 16'd384) || (raster_line_o >= 16'hFF80))
    else $error("raster line out of range");

endmodule

bind palette_ram_and_video_ports pal_checker u_pal_checker (.*);
